// ===== rtl/generational_handle_allocator_defines.svh =====
// Assertion macros shared by the handle allocator RTL.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
// Condition must hold at every clock edge out of reset.
`define GHA_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent at one edge implies consequent at the next edge.
`define GHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GHA_ASSERT_NOW(lbl, cond, msg)
`define GHA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/ghal_pkg.sv =====
// Shared types and constants of the handle allocator.
`timescale 1ns / 1ps
`default_nettype none
package ghal_pkg;

  localparam int CFG_W = 10;
  localparam logic [CFG_W-1:0] CFG_RESET = 10'd64;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_QUERY   = 2'd2
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_INDEX   = 2'd1,
    ST_UNISSUED   = 2'd2,
    ST_QUEUE_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RES_CODE,       // status code only, other fields zero
    RES_FRESH,      // newly issued index, generation zero
    RES_REUSE,      // index popped from the free queue
    RES_DESTROYED,  // destroy done
    RES_QUERY       // alive compare
  } res_sel_t;

  typedef struct packed {
    logic     latch_in;
    logic     pop_q;
    logic     alloc_fresh;
    logic     rd_gen_hidx;
    logic     rd_gen_q;
    logic     commit_destroy;
    logic     set_res;
    res_sel_t res_sel;
    status_t  res_code;
    logic     load_out;
  } ghal_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       can_reuse;
    logic       can_fresh;
    logic       issued;
    logic       q_full;
  } ghal_stat_t;

endpackage
`default_nettype wire

// ===== rtl/ghal_dp.sv =====
// Allocator datapath: counters, generation memory, free queue, result registers.
`timescale 1ns / 1ps
`default_nettype none
`include "generational_handle_allocator_defines.svh"
module ghal_dp
  import ghal_pkg::*;
#(
  parameter int INDEX_BITS = 10,
  parameter int GEN_BITS   = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ghal_cmd_t             cmd,
  output ghal_stat_t                 stat,
  input  wire logic [1:0]            in_cmd,
  input  wire logic [INDEX_BITS-1:0] in_handle_index,
  input  wire logic [GEN_BITS-1:0]   in_handle_generation,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_W-1:0]      cfg_data,
  output logic [1:0]                 out_status,
  output logic [INDEX_BITS-1:0]      out_index,
  output logic [GEN_BITS-1:0]        out_generation,
  output logic                       out_is_alive
);

  localparam int SLOTS = 2 ** INDEX_BITS;
  localparam int CNT_W = INDEX_BITS + 1;
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [GEN_BITS-1:0]   gen_mem [SLOTS];
  logic [INDEX_BITS-1:0] free_q  [SLOTS];

  logic [CFG_W-1:0]      min_free_r;
  logic [INDEX_BITS-1:0] head_r, tail_r;
  logic [CNT_W-1:0]      count_r, fresh_r;

  logic [1:0]            cmd_r;
  logic [INDEX_BITS-1:0] hidx_r;
  logic [GEN_BITS-1:0]   hgen_r;

  logic [INDEX_BITS-1:0] q_rdata_r;
  logic [GEN_BITS-1:0]   gen_rdata_r;

  logic [1:0]            res_status_r;
  logic [INDEX_BITS-1:0] res_index_r;
  logic [GEN_BITS-1:0]   res_gen_r;
  logic                  res_alive_r;

  logic [1:0]            res_status_nxt;
  logic [INDEX_BITS-1:0] res_index_nxt;
  logic [GEN_BITS-1:0]   res_gen_nxt;
  logic                  res_alive_nxt;

  logic                  gen_we;
  logic [INDEX_BITS-1:0] gen_waddr, gen_raddr;
  logic [GEN_BITS-1:0]   gen_wdata;

  always_comb begin
    stat.cmd       = cmd_r;
    stat.can_reuse = CMP_W'(count_r) > CMP_W'(min_free_r);
    stat.can_fresh = !fresh_r[INDEX_BITS];
    stat.issued    = CNT_W'(hidx_r) < fresh_r;
    stat.q_full    = count_r[INDEX_BITS];
  end

  assign gen_we    = cmd.alloc_fresh || cmd.commit_destroy;
  assign gen_waddr = cmd.alloc_fresh ? fresh_r[INDEX_BITS-1:0] : hidx_r;
  assign gen_wdata = cmd.alloc_fresh ? '0 : gen_rdata_r + GEN_BITS'(1);
  assign gen_raddr = cmd.rd_gen_q ? q_rdata_r : hidx_r;

  // memories
  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    if (cmd.rd_gen_hidx || cmd.rd_gen_q) begin
      gen_rdata_r <= gen_mem[gen_raddr];
    end
    if (cmd.commit_destroy) begin
      free_q[tail_r] <= hidx_r;
    end
    if (cmd.pop_q) begin
      q_rdata_r <= free_q[head_r];
    end
  end

  // control counters and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_free_r <= CFG_RESET;
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      fresh_r    <= '0;
    end else begin
      if (cfg_we) begin
        min_free_r <= cfg_data;
      end
      if (cmd.pop_q) begin
        head_r  <= head_r + INDEX_BITS'(1);
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.commit_destroy) begin
        tail_r  <= tail_r + INDEX_BITS'(1);
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.alloc_fresh) begin
        fresh_r <= fresh_r + CNT_W'(1);
      end
    end
  end

  // result fields not selected stay zero
  always_comb begin
    res_status_nxt = ST_OK;
    res_index_nxt  = '0;
    res_gen_nxt    = '0;
    res_alive_nxt  = 1'b0;
    unique case (cmd.res_sel)
      RES_CODE:      res_status_nxt = cmd.res_code;
      RES_FRESH:     res_index_nxt  = fresh_r[INDEX_BITS-1:0];
      RES_REUSE: begin
        res_index_nxt = q_rdata_r;
        res_gen_nxt   = gen_rdata_r;
      end
      RES_DESTROYED: res_status_nxt = ST_OK;
      RES_QUERY:     res_alive_nxt  = (gen_rdata_r == hgen_r);
      default:       res_status_nxt = ST_OK;
    endcase
  end

  // transaction payload and results
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r  <= in_cmd;
      hidx_r <= in_handle_index;
      hgen_r <= in_handle_generation;
    end
    if (cmd.set_res) begin
      res_status_r <= res_status_nxt;
      res_index_r  <= res_index_nxt;
      res_gen_r    <= res_gen_nxt;
      res_alive_r  <= res_alive_nxt;
    end
    if (cmd.load_out) begin
      out_status     <= res_status_r;
      out_index      <= res_index_r;
      out_generation <= res_gen_r;
      out_is_alive   <= res_alive_r;
    end
  end

  `GHA_ASSERT_NOW(a_count_bound, (count_r <= CNT_W'(SLOTS)), "free count above slot count")
  `GHA_ASSERT_NOW(a_queue_ptrs, (tail_r - head_r) == count_r[INDEX_BITS-1:0], "pointer/count mismatch")
  `GHA_ASSERT_NOW(a_no_dual_update, !(cmd.pop_q && cmd.commit_destroy), "queue pop and push in one cycle")

endmodule
`default_nettype wire

// ===== rtl/ghal_ctrl.sv =====
// Allocator controller: sequences each transaction and owns the handshakes.
`timescale 1ns / 1ps
`default_nettype none
`include "generational_handle_allocator_defines.svh"
module ghal_ctrl
  import ghal_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire ghal_stat_t stat,
  output ghal_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_Q_WAIT,
    S_G_WAIT,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.res_sel  = RES_CODE;
    cmd.res_code = ST_OK;
    state_nxt    = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.latch_in = in_valid;
        if (in_valid) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_RESULT;
        unique case (stat.cmd)
          CMD_CREATE: begin
            if (stat.can_reuse) begin
              cmd.pop_q = 1'b1;
              state_nxt = S_Q_WAIT;
            end else if (stat.can_fresh) begin
              cmd.alloc_fresh = 1'b1;
              cmd.set_res     = 1'b1;
              cmd.res_sel     = RES_FRESH;
            end else begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ST_NO_INDEX;
            end
          end
          CMD_DESTROY: begin
            if (!stat.issued) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ST_UNISSUED;
            end else if (stat.q_full) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ST_QUEUE_FULL;
            end else begin
              cmd.rd_gen_hidx = 1'b1;
              state_nxt       = S_G_WAIT;
            end
          end
          CMD_QUERY: begin
            if (!stat.issued) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ST_UNISSUED;
            end else begin
              cmd.rd_gen_hidx = 1'b1;
              state_nxt       = S_G_WAIT;
            end
          end
          default: begin
            cmd.set_res = 1'b1;
          end
        endcase
      end
      S_Q_WAIT: begin
        cmd.rd_gen_q = 1'b1;
        state_nxt    = S_G_WAIT;
      end
      S_G_WAIT: begin
        cmd.set_res = 1'b1;
        state_nxt   = S_RESULT;
        unique case (stat.cmd)
          CMD_CREATE: cmd.res_sel = RES_REUSE;
          CMD_DESTROY: begin
            cmd.res_sel        = RES_DESTROYED;
            cmd.commit_destroy = 1'b1;
          end
          default: cmd.res_sel = RES_QUERY;
        endcase
      end
      S_RESULT: begin
        cmd.load_out = !out_valid_r || !out_stall;
        if (cmd.load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `GHA_ASSERT_NEXT(a_gwait_to_result, state_r == S_G_WAIT, state_r == S_RESULT, "generation read not followed by result")
  `GHA_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid_r && (state_r == S_IDLE), "result load did not present output")
  `GHA_ASSERT_NOW(a_no_overwrite, !(cmd.load_out && out_valid_r && out_stall), "pending result overwritten")

endmodule
`default_nettype wire

// ===== rtl/generational_handle_allocator.sv =====
// Top level of the generational handle allocator.
//
// Handles are an index plus a generation. in_cmd selects create, destroy or
// alive query; in_handle_index / in_handle_generation carry the handle.
// Each transaction gives exactly one result on the out_ channel: status,
// created index and generation, and the alive flag.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low. One transaction is in work at a time: in_stall is low only
// while the sequencer is idle. From acceptance to out_valid the sequencer
// passes through decide and result for a fresh create, an error or an unused
// command; destroy and query add one generation memory read between them, and
// a create that reuses a queued index adds a queue read before that read. A
// new transaction is taken only once the previous result has been loaded.
// A finished result waits in the output register while out_stall is high; a
// new transaction is accepted meanwhile and holds in its final state until the
// register frees. cfg_ready is always high; write cfg only while idle.
// Synchronous reset empties the free queue, restarts fresh indices at zero and
// sets the reuse threshold to 64. Memories need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module generational_handle_allocator
  import ghal_pkg::*;
#(
  parameter int INDEX_BITS = 10,
  parameter int GEN_BITS   = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_cmd,
  input  wire logic [INDEX_BITS-1:0] in_handle_index,
  input  wire logic [GEN_BITS-1:0]   in_handle_generation,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 out_status,
  output logic [INDEX_BITS-1:0]      out_index,
  output logic [GEN_BITS-1:0]        out_generation,
  output logic                       out_is_alive,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_W-1:0]      cfg_min_free_before_reuse
);

  ghal_cmd_t  cmd;
  ghal_stat_t stat;

  assign cfg_ready = 1'b1;

  ghal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ghal_dp #(
    .INDEX_BITS (INDEX_BITS),
    .GEN_BITS   (GEN_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_cmd               (in_cmd),
    .in_handle_index      (in_handle_index),
    .in_handle_generation (in_handle_generation),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_data             (cfg_min_free_before_reuse),
    .out_status           (out_status),
    .out_index            (out_index),
    .out_generation       (out_generation),
    .out_is_alive         (out_is_alive)
  );

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench of the generational handle allocator.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import ghal_pkg::*;

  localparam int IDX_W = 10;
  localparam int GEN_W = 8;
  localparam int SLOTS = 1 << IDX_W;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int TIMEOUT_NS = 1_000_000;
  localparam logic [IDX_W-1:0] HOT_INDEX = 10'd7;
  localparam int WRAP_DESTROYS = 260;
  localparam int OPS_PER_PHASE = 40;
  localparam int DUE_DEPTH = 8;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] index;
    logic [GEN_W-1:0] generation;
    logic             alive;
  } reply_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_cmd;
  logic [IDX_W-1:0] in_handle_index;
  logic [GEN_W-1:0] in_handle_generation;
  logic out_valid;
  logic out_stall;
  logic [1:0] out_status;
  logic [IDX_W-1:0] out_index;
  logic [GEN_W-1:0] out_generation;
  logic out_is_alive;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_min_free_before_reuse;

  generational_handle_allocator #(
    .INDEX_BITS(IDX_W),
    .GEN_BITS  (GEN_W)
  ) dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_cmd                   (in_cmd),
    .in_handle_index          (in_handle_index),
    .in_handle_generation     (in_handle_generation),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_status               (out_status),
    .out_index                (out_index),
    .out_generation           (out_generation),
    .out_is_alive             (out_is_alive),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_min_free_before_reuse(cfg_min_free_before_reuse)
  );

  // Shadow allocator state
  logic [GEN_W-1:0] gen_mem [SLOTS];
  logic [IDX_W-1:0] free_fifo [SLOTS];
  logic [IDX_W-1:0] free_head = '0;
  logic [IDX_W-1:0] free_tail = '0;
  logic [IDX_W:0]   free_count = '0;
  logic [IDX_W:0]   fresh_next = '0;
  logic [CFG_W-1:0] reuse_threshold = CFG_RESET;

  // expected replies in acceptance order
  reply_t replies_due [DUE_DEPTH];
  int due_wr = 0;
  int due_rd = 0;
  int errors = 0;
  int replies_checked = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int holds_done = 0;
  bit hold_req = 1'b0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_CREATE;
    in_handle_index = '0;
    in_handle_generation = '0;
    cfg_valid = 1'b0;
    cfg_min_free_before_reuse = CFG_RESET;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("testbench: done, errors");
    $finish;
  end

  // Computes the reply of one accepted command and updates the shadow state.
  function automatic void apply_handle_cmd(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                                           input logic [GEN_W-1:0] gen);
    reply_t r;
    r = '0;
    case (op)
      CMD_CREATE: begin
        if (free_count > reuse_threshold) begin
          r.index = free_fifo[free_head];
          r.generation = gen_mem[r.index];
          free_head++;
          free_count--;
        end else if (fresh_next < SLOTS) begin
          r.index = fresh_next[IDX_W-1:0];
          gen_mem[r.index] = '0;
          fresh_next++;
        end else begin
          r.status = ST_NO_INDEX;
        end
      end
      CMD_DESTROY: begin
        if (idx >= fresh_next) begin
          r.status = ST_UNISSUED;
        end else if (free_count >= SLOTS) begin
          r.status = ST_QUEUE_FULL;
        end else begin
          gen_mem[idx] = gen_mem[idx] + 1'b1;
          free_fifo[free_tail] = idx;
          free_tail++;
          free_count++;
        end
      end
      CMD_QUERY: begin
        if (idx >= fresh_next) r.status = ST_UNISSUED;
        else r.alive = (gen_mem[idx] == gen);
      end
      default: ;
    endcase
    replies_due[due_wr % DUE_DEPTH] = r;
    due_wr++;
  endfunction

  // Offers one command, in bursts with random gaps, and waits for acceptance.
  task automatic send_op(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                         input logic [GEN_W-1:0] gen);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_cmd = op;
    in_handle_index = idx;
    in_handle_generation = gen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_handle_cmd(op, idx, gen);
  endtask

  task automatic write_reuse_threshold(input logic [CFG_W-1:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (due_wr != due_rd) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_min_free_before_reuse = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reuse_threshold = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    if (fresh_next != 0 && $urandom_range(0, 9) < 8) return IDX_W'($urandom_range(0, fresh_next - 1));
    return IDX_W'($urandom_range(0, SLOTS - 1));
  endfunction

  // Receiver: stall pattern is re-picked at random from three modes; a long hold-off on request.
  initial begin
    int hold_left;
    int mode;
    int cyc;
    hold_left = 0;
    mode = 0;
    cyc = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      if (hold_left == 0 && hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 2) == 0);
          default: out_stall = ((cyc % 7) < 3);
        endcase
      end
    end
  end

  // Compares each result transaction with the oldest expected reply.
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_wr == due_rd) begin
        $display("%0t: unexpected result: status %0d index %0d gen %0d alive %0d", $time,
                 out_status, out_index, out_generation, out_is_alive);
        errors++;
      end else begin
        want = replies_due[due_rd % DUE_DEPTH];
        due_rd++;
        replies_checked++;
        status_seen[out_status]++;
        if (out_status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status,
                   out_status);
          errors++;
        end
        if (out_index !== want.index) begin
          $display("%0t: index mismatch: expected %0d, actual %0d", $time, want.index,
                   out_index);
          errors++;
        end
        if (out_generation !== want.generation) begin
          $display("%0t: generation mismatch: expected %0d, actual %0d", $time,
                   want.generation, out_generation);
          errors++;
        end
        if (out_is_alive !== want.alive) begin
          $display("%0t: is_alive mismatch: expected %0d, actual %0d", $time, want.alive,
                   out_is_alive);
          errors++;
        end
      end
    end
  end

  task automatic test_directed_cases();
    send_op(CMD_DESTROY, '0, '0);         // nothing issued yet
    send_op(CMD_QUERY, '1, '1);
    send_op(CMD_UNUSED, '1, '1);
    send_op(CMD_CREATE, '0, '0);
    send_op(CMD_CREATE, '1, '1);
    send_op(CMD_QUERY, 10'd0, 8'd0);
    send_op(CMD_QUERY, 10'd0, '1);
    send_op(CMD_DESTROY, 10'd0, '0);
    send_op(CMD_DESTROY, 10'd0, '0);      // second destroy of the same handle
    send_op(CMD_QUERY, 10'd0, 8'd2);
    send_op(CMD_DESTROY, 10'd1, '1);
    send_op(CMD_DESTROY, 10'd2, '0);      // one past the issued range
    send_op(CMD_CREATE, '0, '0);          // below threshold: fresh index
    write_reuse_threshold('0);
    send_op(CMD_CREATE, '0, '0);
    send_op(CMD_CREATE, '0, '0);
    send_op(CMD_CREATE, '0, '0);
    send_op(CMD_CREATE, '0, '0);          // queue drained: fresh again
    send_op(CMD_QUERY, 10'd1, 8'd1);
    send_op(CMD_QUERY, 10'd3, 8'd0);
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] levels[5];
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
    int pick;
    levels[0] = '0;
    levels[1] = CFG_W'($urandom_range(1, 16));
    levels[2] = '1;
    levels[3] = CFG_RESET;
    levels[4] = CFG_W'($urandom_range(0, SLOTS - 1));
    for (int phase = 0; phase < 5; phase++) begin
      write_reuse_threshold(levels[phase]);
      if (phase == 1) hold_req = 1'b1;
      for (int n = 0; n < OPS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        idx = pick_index();
        gen = GEN_W'($urandom_range(0, (1 << GEN_W) - 1));
        if (pick < 35) begin
          send_op(CMD_CREATE, idx, gen);
        end else if (pick < 65) begin
          send_op(CMD_DESTROY, idx, gen);
        end else if (pick < 95) begin
          if (idx < fresh_next) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) gen = gen_mem[idx];
            else if (pick < 7) gen = gen_mem[idx] + 1'b1;
            else if (pick < 8) gen = gen_mem[idx] - 1'b1;
          end
          send_op(CMD_QUERY, idx, gen);
        end else begin
          send_op(CMD_UNUSED, idx, gen);
        end
      end
    end
  endtask

  // Bumps one handle's generation past its wrap point, then mixes traffic with reuse on.
  task automatic test_generation_wrap();
    logic [IDX_W-1:0] idx;
    write_reuse_threshold('1);
    while (fresh_next <= HOT_INDEX) send_op(CMD_CREATE, '0, '0);
    hold_req = 1'b1;
    for (int n = 0; n < WRAP_DESTROYS; n++) begin
      send_op(CMD_DESTROY, HOT_INDEX, '0);
      if (n % 64 == 63) send_op(CMD_QUERY, HOT_INDEX, gen_mem[HOT_INDEX]);
    end
    send_op(CMD_QUERY, HOT_INDEX, gen_mem[HOT_INDEX]);
    send_op(CMD_QUERY, HOT_INDEX, gen_mem[HOT_INDEX] + 1'b1);
    send_op(CMD_QUERY, HOT_INDEX, gen_mem[HOT_INDEX] - 1'b1);
    write_reuse_threshold('0);
    for (int n = 0; n < 20; n++) begin
      idx = pick_index();
      case ($urandom_range(0, 2))
        0: send_op(CMD_CREATE, idx, '0);
        1: send_op(CMD_DESTROY, idx, '0);
        default: send_op(CMD_QUERY, idx, gen_mem[idx]);
      endcase
    end
    write_reuse_threshold(CFG_RESET);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_cases();
    test_random_traffic();
    test_generation_wrap();
    @(negedge clk);
    in_valid = 1'b0;
    while (due_wr != due_rd) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("testbench: %0d replies checked, status ok/no-index/unissued/queue-full %0d/%0d/%0d/%0d",
             replies_checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    $display("testbench: %0d long output hold-offs; thresholds 0 to 1023 and a generation wrap",
             holds_done);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== generational_handle_allocator.f =====
+incdir+rtl
rtl/ghal_pkg.sv
rtl/ghal_dp.sv
rtl/ghal_ctrl.sv
rtl/generational_handle_allocator.sv
sim/testbench.sv
